// File: rtl/tbde_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbde_pkg
// Shared types and constants for the two-button debounce event unit.
// ----------------------------------------------------------------------------
package tbde_pkg;

  typedef logic [1:0] level_t;
  typedef logic [7:0] phase_t;

  localparam level_t BOTH_PRESSED   = 2'b00;
  localparam level_t BOTH_RELEASED  = 2'b11;

  localparam phase_t PHASE_IDLE        = 8'd0;
  localparam phase_t PHASE_HELD        = 8'd1;
  localparam phase_t PHASE_LAST_SETTLE = 8'd2;

  localparam logic KIND_PRESS   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  localparam phase_t SETTLE_TICKS_RESET = 8'd20;

endpackage

// File: rtl/two_button_debounce_events_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_button_debounce_events_unit
// Debounces two active-low button levels, one sample word per tick, and
// emits press-confirmed and release events.
// ----------------------------------------------------------------------------
//  channel | dir | tdata [7:0]                 | tuser
//  in_     | in  | button_levels [1:0]         | -
//  out_    | out | event_pattern [1:0]         | event_kind (0 press, 1 release)
//  cfg_    | in  | settle_ticks [7:0] (wr_en)  | -
//
// One sample word per cycle; each word updates the pattern and phase registers
// in the cycle it is accepted, and its event (if any) appears on the output
// register the next cycle. The output register is replaced in the cycle it is
// taken, so a stalled output only blocks input while an event waits.
// Reset (synchronous, rst_n low): both released, idle, settle_ticks = 20.
// ----------------------------------------------------------------------------
module two_button_debounce_events_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,     // [1:0] button_levels
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,    // [1:0] event_pattern
  output logic       out_tuser,    // [0] event_kind
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data   // settle_ticks
);
  import tbde_pkg::*;

  level_t stable_r, stable_nxt;
  phase_t phase_r, phase_nxt;
  phase_t settle_r;

  logic   out_valid_r, out_valid_nxt;
  logic   out_kind_r, out_kind_nxt;
  level_t out_pat_r, out_pat_nxt;

  level_t level;
  logic   changed;
  logic   accept;
  logic   emit;
  logic   emit_kind;
  level_t emit_pat;

  assign level     = in_tdata[1:0];
  assign changed   = (level != stable_r);
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    stable_nxt = stable_r;
    phase_nxt  = phase_r;
    emit       = 1'b0;
    emit_kind  = KIND_PRESS;
    emit_pat   = stable_r;
    priority if (phase_r == PHASE_IDLE) begin
      if (changed) begin
        stable_nxt = level;
        phase_nxt  = settle_r;
      end
    end else if (phase_r == PHASE_HELD) begin
      if (changed) begin
        stable_nxt = level;
        if (level == BOTH_PRESSED) begin
          phase_nxt = settle_r;
        end else begin
          // release carries the old pattern; stay held if both were down
          emit      = 1'b1;
          emit_kind = KIND_RELEASE;
          phase_nxt = (stable_r != BOTH_PRESSED) ? PHASE_IDLE : PHASE_HELD;
        end
      end
    end else if (phase_r == PHASE_LAST_SETTLE) begin
      if (changed) begin
        stable_nxt = level;
        phase_nxt  = PHASE_IDLE;
      end else begin
        emit      = 1'b1;
        emit_kind = KIND_PRESS;
        phase_nxt = PHASE_HELD;
      end
    end else begin
      if (changed) begin
        stable_nxt = level;
        phase_nxt  = PHASE_IDLE;
      end else begin
        phase_nxt = phase_r - 8'd1;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_pat_nxt   = out_pat_r;
    if (accept) begin
      out_valid_nxt = emit;
      out_kind_nxt  = emit_kind;
      out_pat_nxt   = emit_pat;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r    <= BOTH_RELEASED;
      phase_r     <= PHASE_IDLE;
      settle_r    <= SETTLE_TICKS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        stable_r <= stable_nxt;
        phase_r  <= phase_nxt;
      end
      if (cfg_wr_en) begin
        settle_r <= cfg_wr_data;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r <= out_kind_nxt;
    out_pat_r  <= out_pat_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {6'b000000, out_pat_r};

  // an event is only ever left behind in the held or idle phase
  a_evt_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (phase_r == PHASE_HELD || phase_r == PHASE_IDLE))
    else $error("event pending outside held/idle phase");

  // a stable pattern at the last settle step gives a press next cycle
  a_press: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && phase_r == PHASE_LAST_SETTLE && !changed)
      |=> (out_tvalid && out_tuser == KIND_PRESS && phase_r == PHASE_HELD))
    else $error("confirmed press not emitted");

  // debounce state is frozen while an event waits to be taken
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> ($stable(phase_r) && $stable(stable_r)))
    else $error("state moved under output stall");

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level check of the two-button debounce event unit. Sample words are
// queued by the stimulus block and driven with random gaps. A local model of
// the debounce phases predicts each press and release event. The output side
// stalls at random, and every taken event is compared with the oldest
// prediction. settle_ticks is rewritten between phases, once the unit has
// drained.
// ----------------------------------------------------------------------------
module tb_top;
  import tbde_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic   kind;
    level_t pattern;
  } button_event_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'd0;     // [1:0] button_levels
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;           // [1:0] event_pattern
  logic       out_tuser;           // [0] event_kind
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = 8'd0;  // settle_ticks

  // model state
  level_t     rec_pattern = BOTH_RELEASED;
  phase_t     phase_cnt = PHASE_IDLE;
  phase_t     settle_cfg = SETTLE_TICKS_RESET;

  level_t        sample_q[$];
  button_event_t pending_events[$];
  int            words_queued = 0;
  int            words_taken = 0;
  bit            word_taken = 1'b0;
  int            err_cnt = 0;
  int            cycles = 0;
  int            in_gap = 0;
  int            in_calm = 0;
  int            out_stall = 0;
  int            out_calm = 0;

  two_button_debounce_events_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advances the debounce model by one sample; returns 1 when an event results.
  function automatic bit debounce_tick(input level_t lvl, output button_event_t ev);
    bit moved;
    moved = (lvl != rec_pattern);
    ev = '0;
    if (phase_cnt == PHASE_IDLE) begin
      if (moved) begin
        rec_pattern = lvl;
        phase_cnt = settle_cfg;
      end
      return 1'b0;
    end
    if (phase_cnt == PHASE_HELD) begin
      if (!moved) return 1'b0;
      if (lvl == BOTH_PRESSED) begin
        rec_pattern = lvl;
        phase_cnt = settle_cfg;
        return 1'b0;
      end
      ev.kind = KIND_RELEASE;
      ev.pattern = rec_pattern;
      // releasing one of two pressed buttons keeps the unit held
      phase_cnt = (rec_pattern != BOTH_PRESSED) ? PHASE_IDLE : PHASE_HELD;
      rec_pattern = lvl;
      return 1'b1;
    end
    if (phase_cnt == PHASE_LAST_SETTLE && !moved) begin
      ev.kind = KIND_PRESS;
      ev.pattern = rec_pattern;
      phase_cnt = PHASE_HELD;
      return 1'b1;
    end
    if (moved) begin
      phase_cnt = PHASE_IDLE;
      rec_pattern = lvl;
    end else begin
      phase_cnt = phase_cnt - 8'd1;
    end
    return 1'b0;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void push_run(input level_t lvl, input int len);
    for (int i = 0; i < len; i++) sample_q.push_back(lvl);
    words_queued += len;
  endfunction

  // Sampling side: events taken, words accepted, register writes.
  always @(posedge clk) begin : sample_side
    button_event_t got;
    button_event_t want;
    button_event_t ev;
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL two_button_debounce_events_unit");
      $finish;
    end else if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.kind = out_tuser;
        got.pattern = out_tdata[1:0];
        if (pending_events.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("unexpected event: kind %0d pattern %0d", got.kind, got.pattern);
        end else begin
          want = pending_events.pop_front();
          if (got != want) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("event mismatch: expected kind %0d pattern %0d, got kind %0d pattern %0d",
                       want.kind, want.pattern, got.kind, got.pattern);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (debounce_tick(in_tdata[1:0], ev)) pending_events.push_back(ev);
        words_taken++;
        word_taken = 1'b1;
      end
      if (cfg_wr_en) settle_cfg = cfg_wr_data;
    end
  end

  always @(negedge clk) begin : drive_in
    logic       nv;
    logic [7:0] nd;
    nv = in_tvalid;
    nd = in_tdata;
    if (rst_n) begin
      if (word_taken) begin
        nv = 1'b0;
        word_taken = 1'b0;
      end
      if (!nv) begin
        if (in_gap != 0) begin
          in_gap--;
        end else if (sample_q.size() != 0) begin
          nd = {6'd0, sample_q.pop_front()};
          nv = 1'b1;
          if (in_calm != 0) begin
            in_calm--;
          end else begin
            in_gap = idle_len();
            if ($urandom_range(0, 49) == 0) in_calm = $urandom_range(20, 80);
          end
        end
      end
    end
    in_tvalid <= nv;
    in_tdata  <= nd;
  end

  always @(negedge clk) begin : drive_out
    logic nr;
    nr = 1'b1;
    if (out_calm != 0) begin
      out_calm--;
    end else begin
      if (out_stall == 0) begin
        out_stall = idle_len();
        if ($urandom_range(0, 49) == 0) out_calm = $urandom_range(20, 80);
      end
      if (out_stall != 0) begin
        nr = 1'b0;
        out_stall--;
      end
    end
    out_tready <= nr;
  end

  task automatic write_settle(input logic [7:0] ticks);
    @(negedge clk);
    cfg_wr_data <= ticks;
    cfg_wr_en   <= 1'b1;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Sender holds off until every word is in and every event is out.
  task automatic drain();
    wait (words_taken == words_queued && pending_events.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  // Mostly runs long enough to confirm a press, with bounces mixed in.
  task automatic random_phase(input logic [7:0] ticks, input int budget);
    int     n;
    int     len;
    int     sel;
    level_t lvl;
    n = 0;
    while (n < budget) begin
      lvl = level_t'($urandom_range(0, 3));
      sel = $urandom_range(0, 9);
      if (sel < 7) len = int'(ticks) + $urandom_range(0, 3);
      else if (sel < 9) len = $urandom_range(1, 3);
      else len = $urandom_range(1, int'(ticks) + 4);
      if (len < 1) len = 1;
      push_run(lvl, len);
      n += len;
    end
    drain();
  endtask

  initial begin : stimulus
    logic [7:0] settings[10];
    settings = '{8'd2, 8'd3, 8'd255, 8'd20, 8'd5, 8'd1, 8'd0, 8'd0, 8'd0, 8'd2};
    settings[7] = 8'($urandom_range(2, 12));
    settings[8] = 8'($urandom_range(2, 12));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settle value: start settling, then abort well above the last step
    push_run(2'd3, 1);
    push_run(2'd0, 1);
    push_run(2'd3, 1);
    drain();

    // settle of two, from idle with both released
    write_settle(8'd2);
    push_run(2'd3, 1);
    push_run(2'd2, 3);   // press, then held
    push_run(2'd3, 1);   // release of one button
    push_run(2'd0, 2);   // both pressed confirmed
    push_run(2'd1, 2);   // one let go: release of both, still held
    push_run(2'd0, 1);   // back to both pressed restarts settling
    push_run(2'd3, 1);   // change on the last settle step
    push_run(2'd1, 1);
    push_run(2'd2, 2);
    push_run(2'd3, 2);   // press with nothing pressed
    push_run(2'd2, 1);
    drain();

    // settle of one goes straight to held
    write_settle(8'd1);
    push_run(2'd0, 1);
    push_run(2'd3, 1);
    push_run(2'd2, 1);
    push_run(2'd0, 1);
    drain();

    // settle of zero never confirms
    write_settle(8'd0);
    push_run(2'd3, 1);
    push_run(2'd1, 1);
    push_run(2'd2, 2);
    drain();

    foreach (settings[i]) begin
      write_settle(settings[i]);
      random_phase(settings[i], (settings[i] == 8'd255) ? 560 : 85);
    end

    drain();
    repeat (16) @(posedge clk);
    if (err_cnt == 0 && pending_events.size() == 0) begin
      $display("PASS two_button_debounce_events_unit");
    end else begin
      $display("FAIL two_button_debounce_events_unit");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/tbde_pkg.sv
rtl/two_button_debounce_events_unit.sv
verif/tb_top.sv
